### hdl/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types for the fan triangulator: queue status and back-end states.
// ----------------------------------------------------------------------------
package fpt_pkg;

  typedef struct packed {
    logic empty;
    logic full;
  } fpt_q_stat_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PREP,
    B_MUL,
    B_ABS,
    B_NORM,
    B_SQ,
    B_SQRT,
    B_DIVI,
    B_DIV,
    B_EMIT
  } fpt_bstate_t;

endpackage

### hdl/fpt_queue.sv
// ----------------------------------------------------------------------------
// fpt_queue
// Two-entry triangle queue between the fan tracker and the normal engine.
// ----------------------------------------------------------------------------
module fpt_queue #(
  parameter int DW = 480
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DW-1:0]        wr_data,
  input  logic                 pop,
  output logic [DW-1:0]        rd_data,
  output fpt_pkg::fpt_q_stat_t stat
);
  import fpt_pkg::*;

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("pop from empty queue");
`endif

endmodule

### hdl/fpt_front.sv
// ----------------------------------------------------------------------------
// fpt_front
// Fan tracker: keeps first and previous vertex, forms fan triangles.
// ----------------------------------------------------------------------------
module fpt_front #(
  parameter int COORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [5*COORD_BITS-1:0] cur_vtx,
  input  logic                    last,
  output logic                    push,
  output logic [15*COORD_BITS-1:0] tri_data
);
  import fpt_pkg::*;

  localparam int VW = 5 * COORD_BITS;

  logic [VW-1:0] first_r, first_nxt;
  logic [VW-1:0] prev_r, prev_nxt;
  logic [1:0]    seen_r, seen_nxt;

  always_comb begin
    first_nxt = first_r;
    prev_nxt  = prev_r;
    seen_nxt  = seen_r;
    push      = 1'b0;
    if (accept) begin
      case (seen_r)
        2'd0: begin
          first_nxt = cur_vtx;
          prev_nxt  = cur_vtx;
          seen_nxt  = 2'd1;
        end
        2'd1: begin
          prev_nxt = cur_vtx;
          seen_nxt = 2'd2;
        end
        default: begin
          push     = 1'b1;
          prev_nxt = cur_vtx;
        end
      endcase
      if (last) begin
        seen_nxt = 2'd0;
      end
    end
  end

  // winding flipped: previous, first, current
  assign tri_data = {prev_r, first_r, cur_vtx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      prev_r  <= '0;
      seen_r  <= 2'd0;
    end else begin
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

### hdl/fpt_back.sv
// ----------------------------------------------------------------------------
// fpt_back
// Normal engine: cross product, normalize, isqrt, divide, emit three vertices.
// ----------------------------------------------------------------------------
module fpt_back #(
  parameter int COORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fpt_pkg::fpt_q_stat_t            q_stat,
  input  logic [15*COORD_BITS-1:0]        q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [COORD_BITS-1:0]    out_x,
  output logic signed [COORD_BITS-1:0]    out_y,
  output logic signed [COORD_BITS-1:0]    out_z,
  output logic signed [COORD_BITS-1:0]    out_u,
  output logic signed [COORD_BITS-1:0]    out_v,
  output logic signed [15:0]              out_normal_x,
  output logic signed [15:0]              out_normal_y,
  output logic signed [15:0]              out_normal_z,
  output logic                            out_triangle_done
);
  import fpt_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int VW = 5 * C;
  localparam int EW = C + 1;
  localparam int W  = 2 * C + 2;

  fpt_bstate_t state_r, state_nxt;

  logic [3*VW-1:0]       tri_r;
  logic [VW-1:0]         vtx_prev, vtx_first, vtx_cur, vtx_sel;
  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];

  logic [2:0]            prod_idx_r, ld_idx;
  logic [1:0]            comp;
  logic signed [EW-1:0]  op_a, op_b, abs_a, abs_b;
  logic                  ld_neg;
  logic [W-1:0]          mul_a_r;
  logic [EW-1:0]         mul_b_r;
  logic                  mul_neg_r;
  logic signed [W-1:0]   cr_r [3];

  logic [W-1:0]          nm_r [3];
  logic                  neg_r [3];
  logic [W-1:0]          nm_or;

  logic [1:0]            sq_cnt_r;
  logic [29:0]           sq_in;
  logic [59:0]           sq_r;
  logic [61:0]           l2_r;

  logic [63:0]           sx_r, sr_r, sbit_r, s_sum;
  logic [4:0]            sqrt_cnt_r;
  logic [30:0]           len;

  logic [1:0]            div_idx_r;
  logic [3:0]            div_cnt_r;
  logic [44:0]           rem_r, dv_r;
  logic [14:0]           q_r, q_new;
  logic                  div_ge;
  logic [15:0]           nrm_r [3];
  logic [15:0]           nrm_new;

  logic [1:0]            emit_idx_r;
  logic                  out_load;
  logic                  out_valid_r;

  assign vtx_prev  = tri_r[3*VW-1:2*VW];
  assign vtx_first = tri_r[2*VW-1:VW];
  assign vtx_cur   = tri_r[VW-1:0];

  // edges: first - prev and current - prev, per axis x, y, z
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = $signed({vtx_first[(5-k)*C-1], vtx_first[(5-k)*C-1 -: C]})
            - $signed({vtx_prev[(5-k)*C-1], vtx_prev[(5-k)*C-1 -: C]});
      e2[k] = $signed({vtx_cur[(5-k)*C-1], vtx_cur[(5-k)*C-1 -: C]})
            - $signed({vtx_prev[(5-k)*C-1], vtx_prev[(5-k)*C-1 -: C]});
    end
  end

  // product schedule: even index adds, odd index subtracts
  always_comb begin
    ld_idx = (state_r == B_PREP) ? 3'd0 : prod_idx_r + 3'd1;
    case (ld_idx)
      3'd0:    begin op_a = e1[1]; op_b = e2[2]; end
      3'd1:    begin op_a = e1[2]; op_b = e2[1]; end
      3'd2:    begin op_a = e1[2]; op_b = e2[0]; end
      3'd3:    begin op_a = e1[0]; op_b = e2[2]; end
      3'd4:    begin op_a = e1[0]; op_b = e2[1]; end
      default: begin op_a = e1[1]; op_b = e2[0]; end
    endcase
    abs_a  = op_a[EW-1] ? -op_a : op_a;
    abs_b  = op_b[EW-1] ? -op_b : op_b;
    ld_neg = op_a[EW-1] ^ op_b[EW-1] ^ ld_idx[0];
    comp   = prod_idx_r[2:1];
  end

  always_comb begin
    nm_or   = nm_r[0] | nm_r[1] | nm_r[2];
    sq_in   = (sq_cnt_r == 2'd3) ? 30'd0 : nm_r[sq_cnt_r][29:0];
    s_sum   = sr_r + sbit_r;
    len     = sr_r[30:0];
    div_ge  = (rem_r >= dv_r);
    q_new   = {q_r[13:0], div_ge};
    nrm_new = neg_r[div_idx_r] ? -{1'b0, q_new} : {1'b0, q_new};
    case (emit_idx_r)
      2'd0:    vtx_sel = vtx_prev;
      2'd1:    vtx_sel = vtx_first;
      default: vtx_sel = vtx_cur;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_stat.empty) state_nxt = B_PREP;
      B_PREP: state_nxt = B_MUL;
      B_MUL:  if (mul_b_r == '0 && prod_idx_r == 3'd5) state_nxt = B_ABS;
      B_ABS:  state_nxt = B_NORM;
      B_NORM: begin
        if (nm_or == '0) begin
          state_nxt = B_EMIT;
        end else if (!(|nm_or[W-1:30]) && nm_or[29]) begin
          state_nxt = B_SQ;
        end
      end
      B_SQ:   if (sq_cnt_r == 2'd3) state_nxt = B_SQRT;
      B_SQRT: if (sqrt_cnt_r == 5'd31) state_nxt = B_DIVI;
      B_DIVI: state_nxt = B_DIV;
      B_DIV: begin
        if (div_cnt_r == 4'd14) begin
          state_nxt = (div_idx_r == 2'd2) ? B_EMIT : B_DIVI;
        end
      end
      B_EMIT: if (out_load && emit_idx_r == 2'd2) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    q_pop    = (state_r == B_IDLE) && !q_stat.empty;
    out_load = (state_r == B_EMIT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (q_pop) tri_r <= q_data;
      end
      B_PREP: begin
        for (int i = 0; i < 3; i++) cr_r[i] <= '0;
        prod_idx_r <= ld_idx;
        mul_a_r    <= W'(unsigned'(abs_a));
        mul_b_r    <= abs_b;
        mul_neg_r  <= ld_neg;
      end
      B_MUL: begin
        if (mul_b_r != '0) begin
          if (mul_b_r[0]) begin
            cr_r[comp] <= mul_neg_r ? cr_r[comp] - $signed(mul_a_r)
                                    : cr_r[comp] + $signed(mul_a_r);
          end
          mul_a_r <= mul_a_r << 1;
          mul_b_r <= mul_b_r >> 1;
        end else if (prod_idx_r != 3'd5) begin
          prod_idx_r <= ld_idx;
          mul_a_r    <= W'(unsigned'(abs_a));
          mul_b_r    <= abs_b;
          mul_neg_r  <= ld_neg;
        end
      end
      B_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= cr_r[i][W-1];
          nm_r[i]  <= cr_r[i][W-1] ? W'(-cr_r[i]) : W'(cr_r[i]);
        end
      end
      B_NORM: begin
        // one bit a cycle until the largest magnitude sits in [2^29, 2^30)
        if (nm_or == '0) begin
          for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
          emit_idx_r <= 2'd0;
        end else if (|nm_or[W-1:30]) begin
          for (int i = 0; i < 3; i++) nm_r[i] <= nm_r[i] >> 1;
        end else if (!nm_or[29]) begin
          for (int i = 0; i < 3; i++) nm_r[i] <= nm_r[i] << 1;
        end else begin
          sq_cnt_r <= 2'd0;
          l2_r     <= '0;
        end
      end
      B_SQ: begin
        sq_r     <= 60'(sq_in) * 60'(sq_in);
        l2_r     <= l2_r + ((sq_cnt_r != 2'd0) ? 62'(sq_r) : 62'd0);
        sq_cnt_r <= sq_cnt_r + 2'd1;
        if (sq_cnt_r == 2'd3) begin
          sx_r       <= 64'(l2_r) + 64'(sq_r);
          sr_r       <= '0;
          sbit_r     <= 64'd1 << 62;
          sqrt_cnt_r <= '0;
        end
      end
      B_SQRT: begin
        if (sx_r >= s_sum) begin
          sx_r <= sx_r - s_sum;
          sr_r <= (sr_r >> 1) + sbit_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sbit_r     <= sbit_r >> 2;
        sqrt_cnt_r <= sqrt_cnt_r + 5'd1;
        if (sqrt_cnt_r == 5'd31) div_idx_r <= 2'd0;
      end
      B_DIVI: begin
        rem_r     <= {1'b0, nm_r[div_idx_r][29:0], 14'd0} + 45'(len >> 1);
        dv_r      <= {len, 14'd0};
        q_r       <= '0;
        div_cnt_r <= '0;
      end
      B_DIV: begin
        if (div_ge) rem_r <= rem_r - dv_r;
        dv_r      <= dv_r >> 1;
        q_r       <= q_new;
        div_cnt_r <= div_cnt_r + 4'd1;
        if (div_cnt_r == 4'd14) begin
          nrm_r[div_idx_r] <= nrm_new;
          div_idx_r        <= div_idx_r + 2'd1;
          emit_idx_r       <= 2'd0;
        end
      end
      B_EMIT: begin
        if (out_load) begin
          out_x             <= vtx_sel[5*C-1:4*C];
          out_y             <= vtx_sel[4*C-1:3*C];
          out_z             <= vtx_sel[3*C-1:2*C];
          out_u             <= vtx_sel[2*C-1:C];
          out_v             <= vtx_sel[C-1:0];
          out_normal_x      <= nrm_r[0];
          out_normal_y      <= nrm_r[1];
          out_normal_z      <= nrm_r[2];
          out_triangle_done <= (emit_idx_r == 2'd2);
          emit_idx_r        <= emit_idx_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (len != '0)) else $error("divide by zero length");
  a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SQ) |-> (nm_or[29] && !(|nm_or[W-1:30])))
    else $error("magnitudes not normalized");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == B_PREP)) else $error("pop without starting work");
`endif

endmodule

### hdl/polygon_fan_triangulate_flat_normal.sv
// ----------------------------------------------------------------------------
// polygon_fan_triangulate_flat_normal
// Fan triangulator with flat Q2.14 face normals.
// ----------------------------------------------------------------------------
// Input channel: one polygon vertex per request (in_valid / in_stall), with
// in_last_in_polygon closing the fan. From the third vertex of a polygon on,
// each vertex produces one triangle: previous, first, current.
// Output channel: three requests per triangle (out_valid / out_stall), each
// carrying one vertex and the shared normal; out_triangle_done marks the third.
// The fan tracker takes a vertex every cycle while the two-entry triangle
// queue has room; in_stall is high only while the queue is full.
// The normal engine handles one triangle at a time: a shift-add cross product,
// a one-bit-a-cycle normalize, the squares of the three magnitudes, 32 isqrt
// steps and a serial divide for each of the three components, then three
// output requests; a zero cross product goes straight to the output with a
// zero normal. A stalled output holds its request; the engine waits, the
// queue fills and then the input stalls. Reset (synchronous, rst_n low)
// empties the queue and restarts the fan with no vertices seen.
module polygon_fan_triangulate_flat_normal #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_vertex_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_z,
  input  logic signed [COORD_BITS-1:0] in_tex_u,
  input  logic signed [COORD_BITS-1:0] in_tex_v,
  input  logic                         in_last_in_polygon,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic signed [COORD_BITS-1:0] out_u,
  output logic signed [COORD_BITS-1:0] out_v,
  output logic signed [15:0]           out_normal_x,
  output logic signed [15:0]           out_normal_y,
  output logic signed [15:0]           out_normal_z,
  output logic                         out_triangle_done
);
  import fpt_pkg::*;

  localparam int TW = 15 * COORD_BITS;

  fpt_q_stat_t   q_stat;
  logic          accept;
  logic          push;
  logic          pop;
  logic [TW-1:0] tri_wr;
  logic [TW-1:0] tri_rd;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  fpt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cur_vtx  ({in_vertex_x, in_vertex_y, in_vertex_z, in_tex_u, in_tex_v}),
    .last     (in_last_in_polygon),
    .push     (push),
    .tri_data (tri_wr)
  );

  fpt_queue #(.DW(TW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (tri_wr),
    .pop     (pop),
    .rd_data (tri_rd),
    .stat    (q_stat)
  );

  fpt_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_data            (tri_rd),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_u             (out_u),
    .out_v             (out_v),
    .out_normal_x      (out_normal_x),
    .out_normal_y      (out_normal_y),
    .out_normal_z      (out_normal_z),
    .out_triangle_done (out_triangle_done)
  );

endmodule
